FILE: rtl/core/fmne_pkg.sv
// fmne_pkg: shared codes, channel record type and small constant tables
// of the fm channel note and effect engine. No dependencies.
`timescale 1ns / 1ps
package fmne_pkg;

   localparam int PATCH_LEN = 11;
   localparam int OCT_SPAN  = 344;
   localparam int BASE_FNUM = 342;
   localparam int LF_MAX    = 2751;
   localparam int VOL_SPLIT = 50;

   localparam logic [1:0] ACT_LOAD = 2'd0;
   localparam logic [1:0] ACT_NOTE = 2'd1;
   localparam logic [1:0] ACT_ROW  = 2'd2;
   localparam logic [1:0] ACT_TICK = 2'd3;

   localparam logic [1:0] KIND_REG   = 2'd0;
   localparam logic [1:0] KIND_JUMP  = 2'd1;
   localparam logic [1:0] KIND_SPEED = 2'd2;

   localparam logic [3:0] CMD_PORTA_UP   = 4'd1;
   localparam logic [3:0] CMD_PORTA_DOWN = 4'd2;
   localparam logic [3:0] CMD_TONE_SLIDE = 4'd3;
   localparam logic [3:0] CMD_SLIDE_VOL  = 4'd5;
   localparam logic [3:0] CMD_VOL_SLIDE  = 4'd10;
   localparam logic [3:0] CMD_SET_VOL    = 4'd12;
   localparam logic [3:0] CMD_JUMP       = 4'd13;
   localparam logic [3:0] CMD_SPEED      = 4'd15;

   localparam logic [3:0] NOTE_KEY_OFF = 4'd13;

   localparam logic [7:0] REG_FNUM_LO = 8'hA0;
   localparam logic [7:0] REG_FNUM_HI = 8'hB0;
   localparam logic [7:0] REG_FEEDBK  = 8'hC0;
   localparam logic [7:0] REG_CAR_LVL = 8'h43;
   localparam logic [7:0] FEEDBK_BITS = 8'h30;

   typedef struct packed {
      logic [7:0]  level;
      logic [13:0] freq;
      logic [11:0] target;
      logic [7:0]  speed;
      logic [7:0]  porta;
      logic        active;
      logic [7:0]  vstep;
   } chan_type;

   function automatic logic [7:0] op_offset(input logic [3:0] ch);
      logic [7:0] r;
      case (ch)
         4'd0: r = 8'h00;
         4'd1: r = 8'h01;
         4'd2: r = 8'h02;
         4'd3: r = 8'h08;
         4'd4: r = 8'h09;
         4'd5: r = 8'h0A;
         4'd6: r = 8'h10;
         4'd7: r = 8'h11;
         4'd8: r = 8'h12;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [9:0] fnum(input logic [3:0] note);
      logic [9:0] r;
      case (note)
         4'd1:  r = 10'h16b;
         4'd2:  r = 10'h181;
         4'd3:  r = 10'h198;
         4'd4:  r = 10'h1b0;
         4'd5:  r = 10'h1ca;
         4'd6:  r = 10'h1e5;
         4'd7:  r = 10'h202;
         4'd8:  r = 10'h220;
         4'd9:  r = 10'h241;
         4'd10: r = 10'h263;
         4'd11: r = 10'h287;
         4'd12: r = 10'h2ae;
         default: r = 10'h000;
      endcase
      return r;
   endfunction

   // patch byte sent at each step of an instrument load
   function automatic logic [3:0] patch_order(input logic [3:0] k);
      logic [3:0] r;
      case (k)
         4'd8:  r = 4'd9;
         4'd9:  r = 4'd10;
         4'd10: r = 4'd8;
         default: r = k;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] patch_base(input logic [3:0] k);
      logic [7:0] r;
      case (k)
         4'd0: r = 8'h23;
         4'd1: r = 8'h20;
         4'd2: r = 8'h43;
         4'd3: r = 8'h40;
         4'd4: r = 8'h63;
         4'd5: r = 8'h60;
         4'd6: r = 8'h83;
         4'd7: r = 8'h80;
         4'd8: r = 8'hE3;
         4'd9: r = 8'hE0;
         default: r = 8'hC0;
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/core/fmne_if.sv
// fmne_if: valid/ready channels of the engine, request and response items
// no dependencies
`timescale 1ns / 1ps
interface fmne_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [3:0] channel;
   logic [2:0] octave;
   logic [3:0] note;
   logic [3:0] command;
   logic [7:0] param;
   logic [4:0] instrument;
   logic [3:0] patch_byte_index;
   logic [7:0] patch_byte_value;

   modport source (output valid, action, channel, octave, note, command, param,
                   instrument, patch_byte_index, patch_byte_value, input ready);
   modport sink (input valid, action, channel, octave, note, command, param,
                 instrument, patch_byte_index, patch_byte_value, output ready);
endinterface

interface fmne_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] reg_addr;
   logic [7:0] reg_value;
   logic [7:0] argument;
   logic       last;

   modport source (output valid, kind, reg_addr, reg_value, argument, last,
                   input ready);
   modport sink (input valid, kind, reg_addr, reg_value, argument, last,
                 output ready);
endinterface

FILE: rtl/core/fm_channel_note_effect_engine.sv
// fm_channel_note_effect_engine: per-channel note and effect sequencer
// that emits fm chip register writes and jump and speed items; uses fmne_pkg and fmne_if
// Items are taken only in the idle state, so a new item waits until the last is done;
// patch bytes each wait for a memory read state, frequency writes go out one per
// cycle unless the output stalls; row starts and effect ticks walk all channels.
// Reset: synchronous; clears all channel state via valid bits and then
// zeroes the patch memory, one entry a cycle.
`timescale 1ns / 1ps
module fm_channel_note_effect_engine #(
   parameter int NUM_CHANNELS = 9,
   parameter int NUM_PATCHES  = 31
) (
   input logic         clock,
   input logic         reset,
   fmne_req_if.sink    req_ch,
   fmne_rsp_if.source  rsp_ch
);
   import fmne_pkg::*;

   localparam int PDEPTH = NUM_PATCHES * PATCH_LEN;
   localparam int PAW    = $clog2(PDEPTH);
   localparam int CW     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   localparam logic [4:0] S_CLR   = 5'd0;
   localparam logic [4:0] S_IDLE  = 5'd1;
   localparam logic [4:0] S_CRD   = 5'd2;
   localparam logic [4:0] S_CLD   = 5'd3;
   localparam logic [4:0] S_N0    = 5'd4;
   localparam logic [4:0] S_KOFF  = 5'd5;
   localparam logic [4:0] S_PRD   = 5'd6;
   localparam logic [4:0] S_PEM   = 5'd7;
   localparam logic [4:0] S_NF    = 5'd8;
   localparam logic [4:0] S_FA    = 5'd9;
   localparam logic [4:0] S_FB    = 5'd10;
   localparam logic [4:0] S_CMD   = 5'd11;
   localparam logic [4:0] S_WB    = 5'd12;
   localparam logic [4:0] S_FLUSH = 5'd13;
   localparam logic [4:0] S_TP    = 5'd14;
   localparam logic [4:0] S_TS    = 5'd15;
   localparam logic [4:0] S_SETLF = 5'd16;
   localparam logic [4:0] S_TV    = 5'd17;

   // memories
   logic [7:0] pmem [0:PDEPTH-1];
   chan_type   cmem [0:NUM_CHANNELS-1];

   logic [4:0]  st_ff, st_in, ret_ff, ret_in;
   logic [3:0]  ch_ff, ch_in, k_ff, k_in;
   logic [1:0]  act_ff;
   logic [2:0]  oct_ff;
   logic [3:0]  note_ff, cmd_ff;
   logic [7:0]  param_ff;
   logic [4:0]  inst_ff;
   logic [PAW-1:0] clr_ff, clr_in;
   chan_type    wk_ff, wk_in, crd_ff;
   logic [NUM_CHANNELS-1:0] cval_ff;
   logic signed [13:0] lf_ff, lf_in;
   logic [7:0]  prd_ff;

   logic        pv_ff, pv_in, ov_ff, ov_in;
   logic [1:0]  pkind_ff, okind_ff;
   logic [7:0]  paddr_ff, pval_ff, parg_ff, oaddr_ff, oval_ff, oarg_ff;
   logic        olast_ff;

   logic        accept, out_free, can_go, push, emit;
   logic [1:0]  e_kind;
   logic [7:0]  e_addr, e_val, e_arg;
   logic [CW-1:0] cidx;
   logic [7:0]  co;
   logic        inst_ok, ch_ok, load_ok;
   logic [PAW-1:0] praddr, pwaddr;
   logic        pwe;
   logic [9:0]  pr_lin, pw_lin;
   logic [11:0] blk_off, clamp_lf, set_off;
   logic signed [13:0] cur_lf, porta_lf, tgt_lf, up_lf, dn_lf;
   logic [2:0]  set_blk;
   logic [9:0]  set_fn;
   logic signed [9:0] vsum;
   logic [5:0]  vclamp, vset;

   assign accept   = req_ch.valid & req_ch.ready;
   assign req_ch.ready = (st_ff == S_IDLE);
   assign out_free = ~ov_ff | rsp_ch.ready;
   assign can_go   = ~emit | ~pv_ff | out_free;
   assign push     = pv_ff & out_free & (emit | (st_ff == S_FLUSH));

   assign cidx    = ch_ff[CW-1:0];
   assign co      = op_offset(ch_ff);
   assign inst_ok = (inst_ff != 5'd0) && ({27'd0, inst_ff} <= NUM_PATCHES);
   assign ch_ok   = ({28'd0, req_ch.channel} < NUM_CHANNELS);
   assign load_ok = (req_ch.instrument != 5'd0)
                    && ({27'd0, req_ch.instrument} <= NUM_PATCHES)
                    && (req_ch.patch_byte_index < 4'(PATCH_LEN));

   // patch memory addresses
   assign pr_lin = ({5'd0, inst_ff} - 10'd1) * 10'(PATCH_LEN)
                   + {6'd0, patch_order(k_ff)};
   assign pw_lin = ({5'd0, req_ch.instrument} - 10'd1) * 10'(PATCH_LEN)
                   + {6'd0, req_ch.patch_byte_index};
   assign praddr = PAW'(pr_lin);
   assign pwaddr = (st_ff == S_CLR) ? clr_ff : PAW'(pw_lin);
   assign pwe    = (st_ff == S_CLR) | (accept & (req_ch.action == ACT_LOAD) & load_ok);

   // linear frequency of the working channel
   assign blk_off  = 12'(wk_ff.freq[12:10]) * 12'(OCT_SPAN);
   assign cur_lf   = $signed({2'b00, blk_off}) + $signed({4'd0, wk_ff.freq[9:0]})
                     - 14'(BASE_FNUM);
   assign porta_lf = cur_lf + $signed({{6{wk_ff.porta[7]}}, wk_ff.porta});
   assign tgt_lf   = $signed({2'b00, wk_ff.target});
   assign up_lf    = cur_lf + $signed({6'd0, wk_ff.speed});
   assign dn_lf    = cur_lf - $signed({6'd0, wk_ff.speed});

   // clamp and split into block and f-number
   always_comb begin
      if (lf_ff < 0) begin
         clamp_lf = 12'd0;
      end else if (lf_ff > 14'(LF_MAX)) begin
         clamp_lf = 12'(LF_MAX);
      end else begin
         clamp_lf = lf_ff[11:0];
      end
      set_blk = 3'd0;
      for (int b = 1; b < 8; b++) begin
         if (clamp_lf >= 12'(b * OCT_SPAN)) begin
            set_blk = 3'(b);
         end
      end
      set_off = 12'(set_blk) * 12'(OCT_SPAN);
      set_fn  = 10'(clamp_lf - set_off + 12'(BASE_FNUM));
   end

   // volume slide
   always_comb begin
      vsum = $signed({4'd0, ~wk_ff.level[5:0]})
             + $signed({{2{wk_ff.vstep[7]}}, wk_ff.vstep});
      if (vsum < 0) begin
         vclamp = 6'd0;
      end else if (vsum > 10'sd63) begin
         vclamp = 6'd63;
      end else begin
         vclamp = vsum[5:0];
      end
      vset = (param_ff > 8'd63) ? 6'd63 : param_ff[5:0];
   end

   always_comb begin
      st_in  = st_ff;
      ret_in = ret_ff;
      ch_in  = ch_ff;
      k_in   = k_ff;
      clr_in = clr_ff;
      wk_in  = wk_ff;
      lf_in  = lf_ff;
      emit   = 1'b0;
      e_kind = KIND_REG;
      e_addr = 8'd0;
      e_val  = 8'd0;
      e_arg  = 8'd0;
      case (st_ff)
         S_CLR: begin
            clr_in = clr_ff + PAW'(1);
            if (clr_ff == PAW'(PDEPTH - 1)) begin
               st_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               case (req_ch.action)
                  ACT_NOTE: begin
                     ch_in = req_ch.channel;
                     if (ch_ok) begin
                        st_in = S_CRD;
                     end
                  end
                  ACT_ROW, ACT_TICK: begin
                     ch_in = 4'd0;
                     st_in = S_CRD;
                  end
                  default: st_in = S_IDLE;
               endcase
            end
         end
         S_CRD: st_in = S_CLD;
         S_CLD: begin
            wk_in = crd_ff;
            case (act_ff)
               ACT_NOTE: st_in = S_N0;
               ACT_TICK: st_in = S_TP;
               default: begin
                  wk_in.porta  = 8'd0;
                  wk_in.active = 1'b0;
                  wk_in.vstep  = 8'd0;
                  st_in = S_WB;
               end
            endcase
         end
         S_N0: begin
            k_in = 4'd0;
            if (note_ff == 4'd0) begin
               st_in = S_CMD;
            end else if (cmd_ff == CMD_TONE_SLIDE && note_ff < NOTE_KEY_OFF) begin
               wk_in.target = 12'({9'd0, oct_ff} * 12'(OCT_SPAN))
                              + {2'b00, fnum(note_ff)} - 12'(BASE_FNUM);
               if (param_ff != 8'd0) begin
                  wk_in.speed = param_ff;
               end
               wk_in.active = 1'b1;
               st_in = S_WB;
            end else begin
               ret_in = inst_ok ? S_PRD : S_NF;
               st_in  = S_KOFF;
            end
         end
         S_KOFF: begin
            emit   = 1'b1;
            e_addr = REG_FNUM_HI + {4'd0, ch_ff};
            e_val  = {3'd0, wk_ff.freq[12:8]};
            if (can_go) begin
               wk_in.freq[13] = 1'b0;
               st_in = ret_ff;
            end
         end
         S_PRD: st_in = S_PEM;
         S_PEM: begin
            emit = 1'b1;
            if (k_ff == 4'(PATCH_LEN - 1)) begin
               e_addr = REG_FEEDBK + {4'd0, ch_ff};
               e_val  = prd_ff | FEEDBK_BITS;
            end else begin
               e_addr = patch_base(k_ff) + co;
               e_val  = prd_ff;
            end
            if (can_go) begin
               if (k_ff == 4'd2) begin
                  wk_in.level = prd_ff;
               end
               if (k_ff == 4'(PATCH_LEN - 1)) begin
                  st_in = S_NF;
               end else begin
                  k_in  = k_ff + 4'd1;
                  st_in = S_PRD;
               end
            end
         end
         S_NF: begin
            ret_in = S_CMD;
            if (note_ff < NOTE_KEY_OFF) begin
               wk_in.freq = {1'b1, oct_ff, fnum(note_ff)};
               st_in = S_FA;
            end else begin
               st_in = S_KOFF;
            end
         end
         S_FA: begin
            emit   = 1'b1;
            e_addr = REG_FNUM_LO + {4'd0, ch_ff};
            e_val  = wk_ff.freq[7:0];
            if (can_go) begin
               st_in = S_FB;
            end
         end
         S_FB: begin
            emit   = 1'b1;
            e_addr = REG_FNUM_HI + {4'd0, ch_ff};
            e_val  = {2'd0, wk_ff.freq[13:8]};
            if (can_go) begin
               st_in = ret_ff;
            end
         end
         S_CMD: begin
            st_in = S_WB;
            case (cmd_ff)
               CMD_PORTA_UP:   wk_in.porta = param_ff;
               CMD_PORTA_DOWN: wk_in.porta = 8'd0 - param_ff;
               CMD_TONE_SLIDE: begin
                  wk_in.active = 1'b1;
                  if (param_ff != 8'd0) begin
                     wk_in.speed = param_ff;
                  end
               end
               CMD_SLIDE_VOL, CMD_VOL_SLIDE: begin
                  if (cmd_ff == CMD_SLIDE_VOL) begin
                     wk_in.active = 1'b1;
                  end
                  wk_in.vstep = (param_ff < 8'(VOL_SPLIT)) ? 8'd0 - param_ff
                                                           : param_ff - 8'(VOL_SPLIT);
               end
               CMD_SET_VOL: begin
                  emit   = 1'b1;
                  e_addr = REG_CAR_LVL + co;
                  e_val  = {wk_ff.level[7:6], ~vset};
                  wk_in.level = e_val;
                  if (!can_go) begin
                     st_in = S_CMD;
                  end
               end
               CMD_JUMP: begin
                  emit   = 1'b1;
                  e_kind = KIND_JUMP;
                  e_arg  = param_ff;
                  if (!can_go) begin
                     st_in = S_CMD;
                  end
               end
               CMD_SPEED: begin
                  emit   = 1'b1;
                  e_kind = KIND_SPEED;
                  e_arg  = param_ff;
                  if (!can_go) begin
                     st_in = S_CMD;
                  end
               end
               default: st_in = S_WB;
            endcase
         end
         S_TP: begin
            ret_in = S_TS;
            if (wk_ff.porta != 8'd0) begin
               lf_in = porta_lf;
               st_in = S_SETLF;
            end else begin
               st_in = S_TS;
            end
         end
         S_TS: begin
            ret_in = S_TV;
            if (wk_ff.active) begin
               st_in = S_SETLF;
               if (cur_lf < tgt_lf) begin
                  if (up_lf >= tgt_lf) begin
                     lf_in = tgt_lf;
                     wk_in.active = 1'b0;
                  end else begin
                     lf_in = up_lf;
                  end
               end else if (cur_lf > tgt_lf) begin
                  if (dn_lf <= tgt_lf) begin
                     lf_in = tgt_lf;
                     wk_in.active = 1'b0;
                  end else begin
                     lf_in = dn_lf;
                  end
               end else begin
                  lf_in = cur_lf;
                  wk_in.active = 1'b0;
               end
            end else begin
               st_in = S_TV;
            end
         end
         S_SETLF: begin
            wk_in.freq = {wk_ff.freq[13], set_blk, set_fn};
            st_in = S_FA;
         end
         S_TV: begin
            if (wk_ff.vstep != 8'd0) begin
               emit   = 1'b1;
               e_addr = REG_CAR_LVL + co;
               e_val  = {wk_ff.level[7:6], ~vclamp};
               if (can_go) begin
                  wk_in.level = e_val;
                  st_in = S_WB;
               end
            end else begin
               st_in = S_WB;
            end
         end
         S_WB: begin
            if (act_ff != ACT_NOTE && {28'd0, ch_ff} < NUM_CHANNELS - 1) begin
               ch_in = ch_ff + 4'd1;
               st_in = S_CRD;
            end else begin
               st_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (!pv_ff || out_free) begin
               st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   // one result waits in the pending slot so the final one can be marked
   always_comb begin
      pv_in = pv_ff;
      if (emit && can_go) begin
         pv_in = 1'b1;
      end else if (push) begin
         pv_in = 1'b0;
      end
      ov_in = ov_ff;
      if (push) begin
         ov_in = 1'b1;
      end else if (rsp_ch.ready) begin
         ov_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= S_CLR;
         ret_ff  <= S_IDLE;
         clr_ff  <= '0;
         cval_ff <= '0;
         pv_ff   <= 1'b0;
         ov_ff   <= 1'b0;
      end else begin
         st_ff  <= st_in;
         ret_ff <= ret_in;
         clr_ff <= clr_in;
         pv_ff  <= pv_in;
         ov_ff  <= ov_in;
         if (st_ff == S_WB) begin
            cval_ff[cidx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      ch_ff <= ch_in;
      k_ff  <= k_in;
      wk_ff <= wk_in;
      lf_ff <= lf_in;
      if (accept) begin
         act_ff   <= req_ch.action;
         oct_ff   <= req_ch.octave;
         note_ff  <= req_ch.note;
         cmd_ff   <= req_ch.command;
         param_ff <= req_ch.param;
         inst_ff  <= req_ch.instrument;
      end
      if (emit && can_go) begin
         pkind_ff <= e_kind;
         paddr_ff <= e_addr;
         pval_ff  <= e_val;
         parg_ff  <= e_arg;
      end
      if (push) begin
         okind_ff <= pkind_ff;
         oaddr_ff <= paddr_ff;
         oval_ff  <= pval_ff;
         oarg_ff  <= parg_ff;
         olast_ff <= (st_ff == S_FLUSH);
      end
   end

   always_ff @(posedge clock) begin
      if (pwe) begin
         pmem[pwaddr] <= (st_ff == S_CLR) ? 8'd0 : req_ch.patch_byte_value;
      end
      prd_ff <= pmem[praddr];
   end

   always_ff @(posedge clock) begin
      if (st_ff == S_WB) begin
         cmem[cidx] <= wk_ff;
      end
      crd_ff <= cval_ff[cidx] ? cmem[cidx] : '0;
   end

   assign rsp_ch.valid     = ov_ff;
   assign rsp_ch.kind      = okind_ff;
   assign rsp_ch.reg_addr  = oaddr_ff;
   assign rsp_ch.reg_value = oval_ff;
   assign rsp_ch.argument  = oarg_ff;
   assign rsp_ch.last      = olast_ff;

endmodule
